>>> design/ewc_pkg.sv
// Shared types, widths and constants for the event window countdown block.
`default_nettype none
package ewc_pkg;

  localparam int DAY_SECONDS   = 86400;
  localparam int MAX_TIMES_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int TIME_W  = 17;
  localparam int NOW_W   = 32;
  localparam int NEXT_W  = 18;
  localparam int END_W   = 17;
  localparam int OFF_W   = 18;
  localparam int CNT_W   = 5;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // now_seconds mod 86400: 86400 = 675 << 7, quotient from the upper 25 bits
  // times ceil(2^35 / 675), exact for any 25-bit value
  localparam int DAY_LOW_W = 7;
  localparam int RECIP_W   = 26;
  localparam int RECIP_SH  = 35;
  localparam int QUO_W     = 16;
  localparam logic [RECIP_W-1:0] DAY_RECIP = RECIP_W'(50903317);
  // phase mod period: 18-bit dividend
  localparam int DIV_STEPS  = 18;
  localparam int DIV_STEP_W = 5;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIST_MODE    = 3'd0,
    REG_PERIOD_LEN   = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_WINDOW_LEN   = 3'd3,
    REG_TIME_COUNT   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                    list_mode;
    logic [TIME_W-1:0]       period_len;
    logic signed [OFF_W-1:0] phase_offset;
    logic [TIME_W-1:0]       window_len;
    logic [CNT_W-1:0]        time_count;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] sod;
  } item_t;

endpackage
`default_nettype wire

>>> design/ewc_front.sv
// Front end: accepts input beats and reduces query time to second of day.
`default_nettype none
module ewc_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ewc_pkg::IN_DATA_W-1:0] in_tdata,  // entry_index, start_time, now_seconds
  input  wire logic                          in_tuser,  // command
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output ewc_pkg::item_t                     push_item
);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_RED, F_PUSH} fstate_t;

  localparam int HI_W   = ewc_pkg::NOW_W - ewc_pkg::DAY_LOW_W;
  localparam int PROD_W = HI_W + ewc_pkg::RECIP_W;

  fstate_t                          state_r, state_nxt;
  logic                             cmd_r, cmd_nxt;
  logic [ewc_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [ewc_pkg::TIME_W-1:0]       start_r, start_nxt;
  logic [ewc_pkg::NOW_W-1:0]        rem_r, rem_nxt;
  logic [ewc_pkg::QUO_W-1:0]        quo_r, quo_nxt;
  logic [PROD_W-1:0]                prod;
  logic [ewc_pkg::NOW_W-1:0]        quo_day;

  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_item  = '{cmd: cmd_r, idx: idx_r, start: start_r,
                        sod: rem_r[ewc_pkg::TIME_W-1:0]};
  assign prod       = PROD_W'(rem_r[ewc_pkg::NOW_W-1:ewc_pkg::DAY_LOW_W]) *
                      PROD_W'(ewc_pkg::DAY_RECIP);
  assign quo_day    = ewc_pkg::NOW_W'(quo_r) * ewc_pkg::NOW_W'(ewc_pkg::DAY_SECONDS);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          idx_nxt   = in_tdata[3:0];
          start_nxt = in_tdata[20:4];
          rem_nxt   = in_tdata[52:21];
          state_nxt = (in_tuser == ewc_pkg::CMD_QUERY) ? F_MUL : F_PUSH;
        end
      end
      F_MUL: begin
        quo_nxt   = prod[ewc_pkg::RECIP_SH +: ewc_pkg::QUO_W];
        state_nxt = F_RED;
      end
      F_RED: begin
        rem_nxt   = rem_r - quo_day;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

endmodule
`default_nettype wire

>>> design/ewc_queue.sv
// Two-entry queue between front end and back end.
`default_nettype none
module ewc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  input  ewc_pkg::item_t       push_item,
  output logic                 full,
  input  wire logic            pop,
  output ewc_pkg::item_t       pop_item,
  output logic                 empty
);

  ewc_pkg::item_t slot_r [2];
  logic           wp_r, wp_nxt;
  logic           rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push_valid && !full;
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> design/ewc_back.sv
// Back end: start time table, list walk, periodic phase divider, result register.
`default_nettype none
module ewc_back #(
  parameter int MAX_TIMES = ewc_pkg::MAX_TIMES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  ewc_pkg::cfg_t                       cfg,
  input  wire logic                           q_empty,
  input  ewc_pkg::item_t                      q_item,
  output logic                                q_pop,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ewc_pkg::OUT_DATA_W-1:0]      out_tdata  // next_valid, next_seconds, is_active, end_seconds
);

  localparam int AW = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
  localparam int CW = $clog2(MAX_TIMES + 1);
  localparam int TW = ewc_pkg::TIME_W;
  localparam int NW = ewc_pkg::NEXT_W;

  typedef enum logic [2:0] {B_IDLE, B_LIST, B_LFIN, B_PDIV, B_PFIN, B_OUT} bstate_t;

  logic [TW-1:0] mem [MAX_TIMES];
  logic [TW-1:0] rd_data_r;

  bstate_t                        state_r, state_nxt;
  logic [TW-1:0]                  sod_r, sod_nxt;
  logic                           valid_r, valid_nxt;
  logic [NW-1:0]                  next_r, next_nxt;
  logic                           act_r, act_nxt;
  logic [ewc_pkg::END_W-1:0]      end_r, end_nxt;
  logic                           decided_r, decided_nxt;
  logic                           first_r, first_nxt;
  logic [TW-1:0]                  t0_r, t0_nxt;
  logic [CW-1:0]                  iss_r, iss_nxt;
  logic                           rv_r, rv_nxt;
  logic [NW-1:0]                  rem_r, rem_nxt;
  logic [NW-1:0]                  dvd_r, dvd_nxt;
  logic                           neg_r, neg_nxt;
  logic [ewc_pkg::DIV_STEP_W-1:0] step_r, step_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;
  logic [ewc_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [CW-1:0]  cnt_sat;
  logic           mem_we, mem_re;
  logic [NW:0]    diff;
  logic [NW-1:0]  tr;
  logic [NW-1:0]  p_ext;
  logic [NW-1:0]  dur_ext;
  logic [NW-1:0]  phase;
  logic [NW-1:0]  tend;
  logic           lt, inwin;

  assign cnt_sat = (32'(cfg.time_count) > 32'(MAX_TIMES)) ? CW'(MAX_TIMES)
                                                          : CW'(cfg.time_count);
  assign p_ext   = {1'b0, cfg.period_len};
  assign dur_ext = {1'b0, cfg.window_len};
  assign q_pop   = (state_r == B_IDLE) && !q_empty;
  assign mem_we  = q_pop && (q_item.cmd == ewc_pkg::CMD_LOAD) &&
                   (32'(q_item.idx) < 32'(MAX_TIMES));
  assign mem_re  = (state_r == B_LIST) && (iss_r < cnt_sat);

  assign diff  = (NW+1)'($signed({3'b000, q_item.sod})) -
                 (NW+1)'(cfg.phase_offset);
  assign tr    = {rem_r[NW-2:0], dvd_r[NW-1]};
  assign phase = (neg_r && (rem_r != '0)) ? (p_ext - rem_r) : rem_r;
  assign tend  = {1'b0, rd_data_r} + dur_ext;
  assign lt    = (sod_r < rd_data_r);
  assign inwin = ({1'b0, sod_r} < tend);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(q_item.idx)] <= q_item.start;
    end
    if (mem_re) begin
      rd_data_r <= mem[iss_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sod_nxt        = sod_r;
    valid_nxt      = valid_r;
    next_nxt       = next_r;
    act_nxt        = act_r;
    end_nxt        = end_r;
    decided_nxt    = decided_r;
    first_nxt      = first_r;
    t0_nxt         = t0_r;
    iss_nxt        = iss_r;
    rv_nxt         = 1'b0;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    neg_nxt        = neg_r;
    step_nxt       = step_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    case (state_r)
      B_IDLE: begin
        if (!q_empty && (q_item.cmd == ewc_pkg::CMD_QUERY)) begin
          sod_nxt     = q_item.sod;
          valid_nxt   = 1'b0;
          next_nxt    = '0;
          act_nxt     = 1'b0;
          end_nxt     = '0;
          decided_nxt = 1'b0;
          first_nxt   = 1'b1;
          iss_nxt     = '0;
          neg_nxt     = diff[NW];
          dvd_nxt     = diff[NW] ? NW'(-diff) : diff[NW-1:0];
          rem_nxt     = '0;
          step_nxt    = '0;
          if (cfg.list_mode) begin
            if (cnt_sat == '0) begin
              state_nxt = B_OUT;
            end else begin
              valid_nxt = 1'b1;
              state_nxt = B_LIST;
            end
          end else if (cfg.period_len == '0) begin
            state_nxt = B_OUT;
          end else begin
            valid_nxt = 1'b1;
            state_nxt = B_PDIV;
          end
        end
      end
      B_LIST: begin
        if (mem_re) begin
          iss_nxt = iss_r + 1'b1;
          rv_nxt  = 1'b1;
        end
        if (rv_r) begin
          if (first_r) begin
            t0_nxt    = rd_data_r;
            first_nxt = 1'b0;
          end
          if (!decided_r) begin
            if (lt) begin
              next_nxt    = NW'(rd_data_r) - NW'(sod_r);
              decided_nxt = 1'b1;
            end else if (inwin) begin
              next_nxt    = '0;
              decided_nxt = 1'b1;
            end
          end
          if (!act_r && !lt && inwin) begin
            act_nxt = 1'b1;
            end_nxt = ewc_pkg::END_W'(tend - NW'(sod_r));
          end
        end
        if (!mem_re && !rv_r) begin
          state_nxt = B_LFIN;
        end
      end
      B_LFIN: begin
        if (!decided_r) begin
          next_nxt = NW'((NW+1)'(ewc_pkg::DAY_SECONDS) - (NW+1)'(sod_r) + (NW+1)'(t0_r));
        end
        state_nxt = B_OUT;
      end
      B_PDIV: begin
        rem_nxt  = (tr >= p_ext) ? (tr - p_ext) : tr;
        dvd_nxt  = dvd_r << 1;
        step_nxt = step_r + 1'b1;
        if (step_r == ewc_pkg::DIV_STEP_W'(ewc_pkg::DIV_STEPS-1)) begin
          state_nxt = B_PFIN;
        end
      end
      B_PFIN: begin
        next_nxt = p_ext - phase;
        if (phase < dur_ext) begin
          act_nxt = 1'b1;
          end_nxt = ewc_pkg::END_W'(dur_ext - phase);
        end
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, end_r, act_r, next_r, valid_r};
          state_nxt      = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      rv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rv_r         <= rv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    sod_r       <= sod_nxt;
    valid_r     <= valid_nxt;
    next_r      <= next_nxt;
    act_r       <= act_nxt;
    end_r       <= end_nxt;
    decided_r   <= decided_nxt;
    first_r     <= first_nxt;
    t0_r        <= t0_nxt;
    iss_r       <= iss_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    neg_r       <= neg_nxt;
    step_r      <= step_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule
`default_nettype wire

>>> design/event_window_countdown.sv
// Top level of the event window countdown: config registers, front end, queue, back end.
`default_nettype none
// Load beats (tuser 0) write one start second of day into the table and give no result;
// query beats (tuser 1) give one result each. The front end reduces now_seconds to the
// second of day with a reciprocal multiply and a subtract. A two-entry queue then feeds
// the back end, which for a query walks the table at one entry per cycle through its
// registered read port (time_count capped at MAX_TIMES) or, in periodic mode, runs an
// 18-step restoring divider for the phase; a query with no schedule goes straight to
// the result. Front and back overlap, so the sustained rate is set by the slower of
// the two sides. The result sits in an output register and the front end keeps accepting
// while it waits, until the queue fills.
module event_window_countdown #(
  parameter int MAX_TIMES = ewc_pkg::MAX_TIMES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ewc_pkg::IN_DATA_W-1:0]   in_tdata,   // entry_index, start_time, now_seconds
  input  wire logic                            in_tuser,   // command
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ewc_pkg::OUT_DATA_W-1:0]       out_tdata,  // next_valid, next_seconds,
                                                           // is_active, end_seconds
  input  wire logic                            cfg_we,
  input  wire logic [ewc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ewc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ewc_pkg::cfg_t  cfg_r;
  ewc_pkg::item_t push_item;
  ewc_pkg::item_t pop_item;
  logic           push_valid;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ewc_pkg::REG_LIST_MODE:    cfg_r.list_mode    <= cfg_wdata[0];
        ewc_pkg::REG_PERIOD_LEN:   cfg_r.period_len   <= cfg_wdata[16:0];
        ewc_pkg::REG_PHASE_OFFSET: cfg_r.phase_offset <= $signed(cfg_wdata[17:0]);
        ewc_pkg::REG_WINDOW_LEN:   cfg_r.window_len   <= cfg_wdata[16:0];
        ewc_pkg::REG_TIME_COUNT:   cfg_r.time_count   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  ewc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (!q_full),
    .push_item  (push_item)
  );

  ewc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .pop_item   (pop_item),
    .empty      (q_empty)
  );

  ewc_back #(
    .MAX_TIMES (MAX_TIMES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("front end ready right after accepting a beat");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && !q_full) |=> !q_empty)
    else $error("pushed item missing from queue");

endmodule
`default_nettype wire

>>> verif/tb_event_window_countdown.sv
// Self-checking testbench for event_window_countdown: load and query beats against a predictor.
`timescale 1ns / 1ps
module tb_event_window_countdown;

  localparam int SETTLE_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int REPORT_LIMIT    = 10;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_ITEMS     = 140;
  localparam int START_LSB       = ewc_pkg::IDX_W;
  localparam int NOW_LSB         = ewc_pkg::IDX_W + ewc_pkg::TIME_W;
  localparam int DAY             = ewc_pkg::DAY_SECONDS;
  localparam int NTBL            = ewc_pkg::MAX_TIMES_DEF;

  typedef struct packed {
    logic                       cmd;
    logic [ewc_pkg::IDX_W-1:0]  idx;
    logic [ewc_pkg::TIME_W-1:0] start;
    logic [ewc_pkg::NOW_W-1:0]  now;
  } sched_beat_t;

  // same bit order as out_tdata[36:0]
  typedef struct packed {
    logic [ewc_pkg::END_W-1:0]  end_s;
    logic                       active;
    logic [ewc_pkg::NEXT_W-1:0] next_s;
    logic                       valid;
  } countdown_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ewc_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // entry_index, start_time, now_seconds
  logic                           in_tuser = 1'b0; // command
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ewc_pkg::OUT_DATA_W-1:0] out_tdata;       // next_valid, next_seconds, is_active,
                                                   // end_seconds
  logic                           cfg_we = 1'b0;
  logic [ewc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ewc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  event_window_countdown u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // predictor state
  logic                             sch_list = 1'b0;
  logic [ewc_pkg::TIME_W-1:0]       sch_period = '0;
  logic signed [ewc_pkg::OFF_W-1:0] sch_offset = '0;
  logic [ewc_pkg::TIME_W-1:0]       sch_window = '0;
  logic [ewc_pkg::CNT_W-1:0]        sch_count = '0;
  logic [ewc_pkg::TIME_W-1:0]       start_tbl [NTBL] = '{default: '0};

  sched_beat_t beat_q[$];
  countdown_t  countdown_q[$];

  logic        in_fired = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned stall_cycles = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void apply_reg(logic [ewc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [ewc_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      ewc_pkg::REG_LIST_MODE:    sch_list = v[0];
      ewc_pkg::REG_PERIOD_LEN:   sch_period = v[ewc_pkg::TIME_W-1:0];
      ewc_pkg::REG_PHASE_OFFSET: sch_offset = v[ewc_pkg::OFF_W-1:0];
      ewc_pkg::REG_WINDOW_LEN:   sch_window = v[ewc_pkg::TIME_W-1:0];
      ewc_pkg::REG_TIME_COUNT:   sch_count = v[ewc_pkg::CNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic countdown_t predict_countdown(logic [ewc_pkg::NOW_W-1:0] now);
    countdown_t r;
    longint     sod, dur, t, p, phase;
    int         cnt;
    bit         decided;
    r = '0;
    decided = 1'b0;
    sod = longint'(now) % DAY;
    dur = longint'(sch_window);
    if (sch_list) begin
      cnt = (sch_count > NTBL) ? NTBL : int'(sch_count);
      if (cnt > 0) begin
        r.valid = 1'b1;
        for (int i = 0; i < cnt; i++) begin
          t = longint'(start_tbl[i]);
          if (!decided) begin
            if (sod < t) begin
              r.next_s = ewc_pkg::NEXT_W'(t - sod);
              decided = 1'b1;
            end else if (sod < t + dur) begin
              r.next_s = '0;
              decided = 1'b1;
            end
          end
          if (!r.active && sod >= t && sod < t + dur) begin
            r.active = 1'b1;
            r.end_s = ewc_pkg::END_W'(t + dur - sod);
          end
        end
        if (!decided) r.next_s = ewc_pkg::NEXT_W'(DAY - sod + longint'(start_tbl[0]));
      end
    end else if (sch_period != 0) begin
      p = longint'(sch_period);
      phase = ((sod - longint'(sch_offset)) % p + p) % p;
      r.valid = 1'b1;
      r.next_s = ewc_pkg::NEXT_W'(p - phase);
      if (phase < dur) begin
        r.active = 1'b1;
        r.end_s = ewc_pkg::END_W'(dur - phase);
      end
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_fired)) begin
      if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= beat_q[0].cmd;
        in_tdata  <= {3'b000, beat_q[0].now, beat_q[0].start, beat_q[0].idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor, predictor and checker
  always @(posedge clk) begin
    countdown_t got, want, exp_cd;
    in_fired <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_we) apply_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready) begin
        beat_q.delete(0);
        if (in_tuser == ewc_pkg::CMD_LOAD) begin
          if (in_tdata[ewc_pkg::IDX_W-1:0] < NTBL)
            start_tbl[in_tdata[ewc_pkg::IDX_W-1:0]] = in_tdata[START_LSB +: ewc_pkg::TIME_W];
        end else begin
          exp_cd = predict_countdown(in_tdata[NOW_LSB +: ewc_pkg::NOW_W]);
          countdown_q = {countdown_q, exp_cd};
        end
      end
      if (out_tvalid && out_tready) begin
        got = countdown_t'(out_tdata[36:0]);
        if (countdown_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display("unexpected result beat: %h", out_tdata);
        end else begin
          want = countdown_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_LIMIT)
              $display({"result diff: valid %0d/%0d next %0d/%0d active %0d/%0d",
                        " end %0d/%0d (exp/got)"},
                       want.valid, got.valid, want.next_s, got.next_s,
                       want.active, got.active, want.end_s, got.end_s);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("event_window_countdown: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(ewc_pkg::cfg_reg_t r, logic [ewc_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_schedule(logic lm, int per, int off, int win, int cnt);
    write_reg(ewc_pkg::REG_LIST_MODE, ewc_pkg::CFG_DATA_W'(lm));
    write_reg(ewc_pkg::REG_PERIOD_LEN, ewc_pkg::CFG_DATA_W'(per));
    write_reg(ewc_pkg::REG_PHASE_OFFSET, ewc_pkg::CFG_DATA_W'(off));
    write_reg(ewc_pkg::REG_WINDOW_LEN, ewc_pkg::CFG_DATA_W'(win));
    write_reg(ewc_pkg::REG_TIME_COUNT, ewc_pkg::CFG_DATA_W'(cnt));
  endtask

  // sender holds off until every result is back, then the block settles
  task automatic wait_quiet();
    while (beat_q.size() != 0 || countdown_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_load(int idx, int start);
    sched_beat_t b;
    b.cmd   = ewc_pkg::CMD_LOAD;
    b.idx   = ewc_pkg::IDX_W'(idx);
    b.start = ewc_pkg::TIME_W'(start);
    b.now   = $urandom();
    beat_q = {beat_q, b};
  endfunction

  function automatic void queue_query(logic [ewc_pkg::NOW_W-1:0] now);
    sched_beat_t b;
    b.cmd   = ewc_pkg::CMD_QUERY;
    b.idx   = ewc_pkg::IDX_W'($urandom());
    b.start = ewc_pkg::TIME_W'($urandom());
    b.now   = now;
    beat_q = {beat_q, b};
  endfunction

  // often lands near starts and window ends so both edges get hit
  function automatic logic [ewc_pkg::NOW_W-1:0] pick_now();
    longint      day, sod;
    int unsigned r;
    r = $urandom_range(99);
    day = $urandom_range(49709);
    if (r < 35) return $urandom();
    if (r < 75) begin
      if (sch_list)
        sod = longint'(start_tbl[$urandom_range(NTBL-1)]);
      else
        sod = longint'(sch_offset) + longint'($urandom_range(20)) * longint'(sch_period);
      if (r[0]) sod = sod + longint'(sch_window);
      sod = sod + longint'($urandom_range(20)) - 10;
      sod = (sod % DAY + DAY) % DAY;
    end else if (r < 85) begin
      sod = $urandom_range(1) ? 0 : DAY - 1;
    end else begin
      sod = $urandom_range(DAY - 1);
    end
    return ewc_pkg::NOW_W'(day * DAY + sod);
  endfunction

  task automatic run_directed();
    int tbl [NTBL] = '{0, 1800, 5400, 5000, 9000, 12000, 20000, 30000,
                       40000, 50000, 60000, 65536, 70000, 80000, 131071, 86399};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // no schedule after reset
    queue_query(32'd0);
    queue_query(32'hFFFF_FFFF);
    wait_quiet();
    write_schedule(1'b0, DAY, -(DAY - 1), 0, 0);
    queue_query(32'd0);
    queue_query(32'd1);
    queue_query(32'hFFFF_FFFF);
    wait_quiet();
    write_reg(ewc_pkg::REG_WINDOW_LEN, ewc_pkg::CFG_DATA_W'(DAY));
    queue_query(32'd12345);
    wait_quiet();
    // window longer than period
    write_schedule(1'b0, 1, DAY - 1, 131071, 0);
    queue_query(32'd777);
    wait_quiet();
    // unsorted table, a start past the day, count clipped
    for (int i = 0; i < NTBL; i++) queue_load(i, tbl[i]);
    wait_quiet();
    write_schedule(1'b1, 0, 0, 900, 31);
    queue_query(32'd0);
    queue_query(32'd5100);
    queue_query(32'd80100);
    queue_query(ewc_pkg::NOW_W'(3 * DAY + DAY - 1));
    queue_query(32'hFFFF_FFFF);
    wait_quiet();
    write_reg(ewc_pkg::REG_TIME_COUNT, ewc_pkg::CFG_DATA_W'(4));
    queue_query(32'd80000);
    wait_quiet();
    write_reg(ewc_pkg::REG_TIME_COUNT, ewc_pkg::CFG_DATA_W'(0));
    queue_query(32'd100);
    wait_quiet();
  endtask

  task automatic run_phase(int k, int n);
    logic   lm;
    int     per, off, win, cnt;
    longint t;
    case (k)
      0: begin
        lm = 1'b0; per = DAY; off = -(DAY - 1); win = DAY; cnt = 16;
      end
      1: begin
        lm = 1'b1; per = 0; off = 0; win = 0; cnt = 16;
      end
      2: begin
        lm = 1'b0; per = 131071; off = DAY - 1; win = 131071; cnt = 31;
      end
      3: begin
        lm = 1'b1; per = 1; off = -1; win = 3600; cnt = 31;
      end
      default: begin
        lm  = $urandom_range(1);
        per = ($urandom_range(99) < 15) ? $urandom_range(10) : $urandom_range(1, DAY);
        off = int'($urandom_range(2 * DAY - 2)) - (DAY - 1);
        win = lm ? $urandom_range(7200) : $urandom_range(per + per / 2);
        cnt = $urandom_range(31);
      end
    endcase
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
    write_schedule(lm, per, off, win, cnt);
    if (lm) begin
      // sorted day plan first, so windows line up the way users set them
      t = $urandom_range(2000);
      for (int i = 0; i < NTBL; i++) begin
        queue_load(i, int'(t));
        t = t + $urandom_range(600, 5400);
        if (t > DAY - 1) t = DAY - 1;
      end
      while (beat_q.size() != 0) @(posedge clk);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        queue_load($urandom_range(NTBL - 1),
                   ($urandom_range(19) == 0) ? $urandom_range(DAY, 131071)
                                             : $urandom_range(DAY - 1));
      else
        queue_query(pick_now());
    end
    wait_quiet();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (int k = 0; k < RANDOM_PHASES; k++) run_phase(k, PHASE_ITEMS);
    if (mismatch_cnt == 0 && countdown_q.size() == 0)
      $display("event_window_countdown: match");
    else
      $display("event_window_countdown: mismatch");
    $finish;
  end

endmodule
